@@ design/box_non_maximum_suppression_macros.svh @@
// assertion macros shared by the checker
`ifndef BOX_NON_MAXIMUM_SUPPRESSION_MACROS_SVH
`define BOX_NON_MAXIMUM_SUPPRESSION_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define BNMS_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define BNMS_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

@@ design/bnms_pkg.sv @@
package bnms_pkg;
    localparam int DEPTH = 64;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam logic [15:0] THR_RESET = 16'd19661;
    localparam int REG_THR = 0;

    typedef struct packed {
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] box_width;
        logic [15:0] box_height;
        logic [15:0] confidence;
        logic        final_box;
    } t_in;

    typedef struct packed {
        logic [5:0]  source_index;
        logic [15:0] kept_x;
        logic [15:0] kept_y;
        logic [15:0] kept_width;
        logic [15:0] kept_height;
        logic [15:0] kept_score;
        logic        end_of_list;
        logic        capacity_exceeded;
    } t_out;

    typedef enum logic [3:0] {
        S_LOAD, S_SORT_RD, S_SORT_CMP, S_SORT_WR, S_SUP_I, S_SUP_IA,
        S_SUP_J, S_SUP_JA, S_SUP_M1, S_SUP_M2, S_SUP_CMP, S_EMIT, S_OUT, S_FLUSH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       load;        // store the input box
        logic       clr_set;     // clear count, overflow, marks
        logic       sorting;     // rank port reads rank[j-1] instead of rank[i]
        logic       rk_shift;    // rank[j] <= rank[j-1]
        logic       rk_place;    // rank[j] <= i
        logic       ld_a;        // read rank[i] geometry into box a
        logic       ld_b;        // read rank[j] geometry into box b
        logic       mark;        // set suppress mark j
        logic       out_load;    // load output register from box a
        logic       eol;
        logic       op_go;       // advance overlap pipeline
        logic [5:0] i;
        logic [5:0] j;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [6:0] count;
        logic       less;        // score[rank[j-1]] < score[i]
        logic       supp_i;
        logic       supp_j;
        logic       over;        // overlap test result
    } t_stat;
endpackage

@@ design/bnms_datapath.sv @@
module bnms_datapath
    import bnms_pkg::*;
#(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in         i_box,
    input  logic [15:0] i_thr,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output t_out        o_res
);
    localparam logic [15:0] CMASK = 16'((32'd1 << COORD_BITS) - 1);

    logic [63:0] r_geo [DEPTH];
    logic [15:0] r_score [DEPTH];
    logic [5:0]  r_rank [DEPTH];
    logic [DEPTH-1:0] r_supp;
    logic [6:0]  r_count;
    logic        r_ovf;

    logic [5:0]  r_rk_a;
    logic [15:0] r_sc_prev, r_sc_cur;
    logic [63:0] r_ga, r_gb;
    logic [5:0]  r_ia;
    logic [15:0] r_sa;
    logic [5:0]  r_rk_j;
    logic [5:0]  w_rk_addr;

    // rank port a: rank[j-1] while sorting, rank[i] while suppressing
    assign w_rk_addr = i_cmd.sorting ? (i_cmd.j - 6'd1) : i_cmd.i;

    // box store, score store, rank store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_count < 7'(MAX_BOXES)) begin
            r_geo[r_count[5:0]] <= {i_box.box_height & CMASK, i_box.box_width & CMASK,
                                    i_box.center_y & CMASK, i_box.center_x & CMASK};
            r_score[r_count[5:0]] <= i_box.confidence;
        end
        if (i_cmd.rk_shift) r_rank[i_cmd.j] <= r_rk_a;
        else if (i_cmd.rk_place) r_rank[i_cmd.j] <= i_cmd.i;
        r_rk_a    <= r_rank[w_rk_addr];
        r_rk_j    <= r_rank[i_cmd.j];
        r_sc_prev <= r_score[r_rk_a];
        r_sc_cur  <= r_score[i_cmd.i];
        if (i_cmd.ld_a) begin
            r_ga <= r_geo[r_rk_a];
            r_sa <= r_score[r_rk_a];
            r_ia <= r_rk_a;
        end
        if (i_cmd.ld_b) r_gb <= r_geo[r_rk_j];
    end

    // set control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_set) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_supp  <= '0;
        end else begin
            if (i_cmd.load) begin
                if (r_count < 7'(MAX_BOXES)) r_count <= r_count + 7'd1;
                else r_ovf <= 1'b1;
            end
            if (i_cmd.mark) r_supp[i_cmd.j] <= 1'b1;
        end
    end

    // overlap pipeline stage 1: spans and areas
    logic [17:0] alo_x, ahi_x, blo_x, bhi_x, alo_y, ahi_y, blo_y, bhi_y;
    logic signed [18:0] lx, hx, ly, hy, dx, dy;
    logic [17:0] r_ox, r_oy;
    logic [31:0] r_aa, r_ab;
    always_comb begin
        alo_x = {1'b0, r_ga[15:0], 1'b0} - 18'(r_ga[47:32]);
        ahi_x = {1'b0, r_ga[15:0], 1'b0} + 18'(r_ga[47:32]);
        blo_x = {1'b0, r_gb[15:0], 1'b0} - 18'(r_gb[47:32]);
        bhi_x = {1'b0, r_gb[15:0], 1'b0} + 18'(r_gb[47:32]);
        alo_y = {1'b0, r_ga[31:16], 1'b0} - 18'(r_ga[63:48]);
        ahi_y = {1'b0, r_ga[31:16], 1'b0} + 18'(r_ga[63:48]);
        blo_y = {1'b0, r_gb[31:16], 1'b0} - 18'(r_gb[63:48]);
        bhi_y = {1'b0, r_gb[31:16], 1'b0} + 18'(r_gb[63:48]);
        lx = ($signed({alo_x[17], alo_x}) > $signed({blo_x[17], blo_x}))
             ? $signed({alo_x[17], alo_x}) : $signed({blo_x[17], blo_x});
        hx = ({1'b0, ahi_x} < {1'b0, bhi_x}) ? $signed({1'b0, ahi_x}) : $signed({1'b0, bhi_x});
        ly = ($signed({alo_y[17], alo_y}) > $signed({blo_y[17], blo_y}))
             ? $signed({alo_y[17], alo_y}) : $signed({blo_y[17], blo_y});
        hy = ({1'b0, ahi_y} < {1'b0, bhi_y}) ? $signed({1'b0, ahi_y}) : $signed({1'b0, bhi_y});
        dx = hx - lx;
        dy = hy - ly;
    end

    // alo may go negative: span sign kept in bit 17 since 2c-s >= -65535
    logic [34:0] r_inter;
    logic [35:0] r_uni;
    logic [51:0] r_lhs;
    logic [52:0] r_rhs;
    always_ff @(posedge i_clk) begin
        if (i_cmd.op_go) begin
            r_ox <= (hx > lx) ? dx[17:0] : 18'd0;
            r_oy <= (hy > ly) ? dy[17:0] : 18'd0;
            r_aa <= r_ga[47:32] * r_ga[63:48];
            r_ab <= r_gb[47:32] * r_gb[63:48];
            // stage 2: intersection and summed areas
            r_inter <= 35'(r_ox * r_oy);
            r_uni   <= {2'b0, r_aa, 2'b0} + {2'b0, r_ab, 2'b0} + 36'd4;
            // stage 3: compare terms
            r_lhs   <= {1'b0, r_inter, 16'd0};
            r_rhs   <= 53'(i_thr * (r_uni - 36'(r_inter)));
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_res.source_index      <= r_ia;
            o_res.kept_x            <= r_ga[15:0];
            o_res.kept_y            <= r_ga[31:16];
            o_res.kept_width        <= r_ga[47:32];
            o_res.kept_height       <= r_ga[63:48];
            o_res.kept_score        <= r_sa;
            o_res.end_of_list       <= i_cmd.eol;
            o_res.capacity_exceeded <= r_ovf;
        end
    end

    assign o_stat.count  = r_count;
    assign o_stat.less   = r_sc_prev < r_sc_cur;
    assign o_stat.supp_i = r_supp[i_cmd.i];
    assign o_stat.supp_j = r_supp[i_cmd.j];
    assign o_stat.over   = {1'b0, r_lhs} > r_rhs;
endmodule

@@ design/bnms_ctrl.sv @@
module bnms_ctrl
    import bnms_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_final,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;
    logic [5:0] r_i, n_i;
    logic [6:0] r_j, n_j;         // one bit wider so the scan can reach the count
    logic [6:0] r_n, n_n;
    logic [5:0] r_last, n_last;   // held at its reset value; not updated by the controller
    logic       r_have, n_have;   // a kept box waits in box a
    logic [1:0] r_wait, n_wait;
    logic       r_ov, n_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_i <= '0; r_j <= '0; r_n <= '0; r_last <= '0;
            r_have <= 1'b0; r_wait <= '0; r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i <= n_i; r_j <= n_j; r_n <= n_n; r_last <= n_last;
            r_have <= n_have; r_wait <= n_wait; r_ov <= n_ov;
        end
    end

    // sort by insertion, then greedy suppression with a three stage overlap test;
    // a kept box is emitted once the next kept box is known, so end of list is exact
    always_comb begin
        n_state = r_state; n_i = r_i; n_j = r_j; n_n = r_n; n_last = r_last;
        n_have = r_have; n_wait = r_wait; n_ov = r_ov;
        o_cmd = '0;
        o_cmd.i = r_i;
        o_cmd.j = r_j[5:0];
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_final) begin
                        n_i = '0; n_j = '0;
                        n_state = S_SORT_RD;
                    end
                end
            end
            S_SORT_RD: begin
                o_cmd.sorting = 1'b1;
                n_n = i_stat.count;
                if (r_j == 7'd0) begin
                    o_cmd.rk_place = 1'b1;
                    n_state = S_SORT_WR;
                end else begin
                    n_wait = 2'd0;
                    n_state = S_SORT_CMP;
                end
            end
            S_SORT_CMP: begin
                // wait for the rank read and then the score read to register
                o_cmd.sorting = 1'b1;
                if (r_wait != 2'd2) begin
                    n_wait = r_wait + 2'd1;
                end else if (i_stat.less) begin
                    o_cmd.rk_shift = 1'b1;
                    n_j = r_j - 7'd1;
                    n_state = S_SORT_RD;
                end else begin
                    o_cmd.rk_place = 1'b1;
                    n_state = S_SORT_WR;
                end
            end
            S_SORT_WR: begin
                o_cmd.sorting = 1'b1;
                if (7'(r_i) + 7'd1 >= r_n) begin
                    n_i = '0; n_have = 1'b0;
                    n_state = S_SUP_I;
                end else begin
                    n_i = r_i + 6'd1; n_j = 7'(r_i) + 7'd1;
                    n_state = S_SORT_RD;
                end
            end
            S_SUP_I: begin
                if (i_stat.supp_i) begin
                    if (7'(r_i) + 7'd1 >= r_n) n_state = S_FLUSH;
                    else n_i = r_i + 6'd1;
                end else if (r_have) begin
                    // emit the previous kept box before overwriting box a
                    o_cmd.out_load = 1'b1;
                    n_have = 1'b0;
                    n_state = S_OUT;
                end else begin
                    n_state = S_SUP_IA;
                end
            end
            S_SUP_IA: begin
                // rank[i] now registered
                o_cmd.ld_a = 1'b1;
                n_have = 1'b1;
                n_j = 7'(r_i) + 7'd1;
                n_state = S_SUP_J;
            end
            S_SUP_J: begin
                if (r_j >= r_n) begin
                    if (7'(r_i) + 7'd1 >= r_n) n_state = S_FLUSH;
                    else begin
                        n_i = r_i + 6'd1;
                        n_state = S_SUP_I;
                    end
                end else if (i_stat.supp_j) begin
                    n_j = r_j + 7'd1;
                end else begin
                    n_state = S_SUP_JA;
                end
            end
            S_SUP_JA: begin
                o_cmd.ld_b = 1'b1;
                n_state = S_SUP_M1;
            end
            S_SUP_M1: begin
                o_cmd.op_go = 1'b1;
                n_state = S_SUP_M2;
            end
            S_SUP_M2: begin
                o_cmd.op_go = 1'b1;
                n_state = S_SUP_CMP;
            end
            S_SUP_CMP: begin
                o_cmd.op_go = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.over) o_cmd.mark = 1'b1;
                n_j = r_j + 7'd1;
                n_state = S_SUP_J;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (r_ov) begin
                        o_cmd.clr_set = 1'b1;
                        n_ov = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_SUP_IA;
                    end
                end
            end
            S_FLUSH: begin
                // last kept box goes out with end of list
                o_cmd.out_load = 1'b1;
                o_cmd.eol = 1'b1;
                n_have = 1'b0;
                n_ov = 1'b1;
                n_state = S_OUT;
            end
            default: n_state = S_LOAD;
        endcase
    end
endmodule

@@ design/box_non_maximum_suppression.sv @@
// greedy non-maximum suppression over up to MAX_BOXES boxes
// input channel: one box per request, i_in_valid / o_in_ready, one per cycle
//   while loading; the request with final_box set closes the set
// after the final box the block drops o_in_ready, ranks the set by an
//   insertion sort and then runs the greedy suppression pass, testing
//   each pair through a three stage multiply and compare unit; the sort
//   and pass are quadratic in the set size
// output channel: one kept box per request, o_out_valid / i_out_ready, in
//   descending score order, end_of_list on the last one
// a stalled receiver holds the block in its output state, nothing is lost
// boxes past capacity are dropped and capacity_exceeded set on the set
// apb port: overlap_threshold at address 0, pready always high
// reset (synchronous, active low) clears counts and marks and sets the
//   threshold back to its default of about 0.3
module box_non_maximum_suppression
    import bnms_pkg::*;
#(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [15:0] r_thr;
    t_cmd  w_cmd;
    t_stat w_stat;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_thr <= THR_RESET;
        else if (psel && penable && pwrite && paddr == 2'(REG_THR * 4))
            r_thr <= pwdata[15:0];
    end
    assign pready = 1'b1;
    assign prdata = (paddr == 2'(REG_THR * 4)) ? {16'd0, r_thr} : 32'd0;

    bnms_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .i_final(i_in_data.final_box),
        .o_in_ready, .o_out_valid, .i_out_ready,
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    bnms_datapath #(.MAX_BOXES(MAX_BOXES), .COORD_BITS(COORD_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_box(i_in_data), .i_thr(r_thr),
        .i_cmd(w_cmd), .o_stat(w_stat), .o_res(o_out_data)
    );
endmodule

@@ design/bnms_checker.sv @@
`include "box_non_maximum_suppression_macros.svh"
module bnms_checker
    import bnms_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);
    // never both sides open at once
    `BNMS_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    // stalled result holds
    `BNMS_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_data))
    // after the last result the block loads again
    `BNMS_ASSERT_NXT(a_reload, i_clk, i_rst_n,
        o_out_valid && i_out_ready && o_out_data.end_of_list, o_in_ready)
    // ready after reset
    `BNMS_ASSERT_NXT(a_rst, i_clk, 1'b1, !i_rst_n, o_in_ready)
endmodule

bind box_non_maximum_suppression bnms_checker u_chk (
    .i_clk, .i_rst_n, .o_in_ready, .o_out_valid, .i_out_ready,
    .o_out_data
);

@@ tb/box_non_maximum_suppression_tb.sv @@
`timescale 1ns / 100ps

module box_non_maximum_suppression_tb
    import bnms_pkg::*;
();

    localparam int CAPACITY     = 64;
    localparam int STALL_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 50;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    box_non_maximum_suppression u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor state
    t_in         box_queue[$];
    t_out        kept_queue[$];
    logic [63:0] set_geometry[CAPACITY];
    logic [15:0] set_score[CAPACITY];
    int          set_count = 0;
    bit          set_overflow = 1'b0;
    logic [15:0] thr_model;

    int          send_idle_pct;
    int          recv_idle_pct;
    int          mismatches = 0;
    int          stall_ticks = 0;
    bit          timed_out = 1'b0;

    function automatic logic [63:0] edge_overlap(logic [15:0] ca, logic [15:0] sa,
                                                 logic [15:0] cb, logic [15:0] sb);
        longint alo, ahi, blo, bhi, lo, hi;
        alo = 2 * longint'(ca) - longint'(sa);
        ahi = 2 * longint'(ca) + longint'(sa);
        blo = 2 * longint'(cb) - longint'(sb);
        bhi = 2 * longint'(cb) + longint'(sb);
        lo = (alo > blo) ? alo : blo;
        hi = (ahi < bhi) ? ahi : bhi;
        return (hi > lo) ? 64'(hi - lo) : 64'd0;
    endfunction

    // exact iou test in quarter-lsb area units
    function automatic bit iou_above(logic [63:0] a, logic [63:0] b);
        logic [63:0] inter4, area_a4, area_b4, union4;
        inter4 = edge_overlap(a[15:0], a[47:32], b[15:0], b[47:32])
               * edge_overlap(a[31:16], a[63:48], b[31:16], b[63:48]);
        area_a4 = 64'd4 * 64'(a[47:32]) * 64'(a[63:48]);
        area_b4 = 64'd4 * 64'(b[47:32]) * 64'(b[63:48]);
        union4 = area_a4 + area_b4 + 64'd4 - inter4;
        return (inter4 << 16) > 64'(thr_model) * union4;
    endfunction

    // store one box; on the final one rank, suppress and queue the kept boxes
    task automatic predict_box(t_in b);
        int  rank[CAPACITY];
        bit  gone[CAPACITY];
        int  i, j, cur, last_pos;
        t_out r;
        if (set_count < CAPACITY) begin
            set_geometry[set_count] = {b.box_height, b.box_width, b.center_y, b.center_x};
            set_score[set_count] = b.confidence;
            set_count++;
        end else begin
            set_overflow = 1'b1;
        end
        if (!b.final_box) return;
        for (i = 0; i < set_count; i++) begin
            cur = i;
            j = i;
            while (j > 0 && set_score[rank[j-1]] < set_score[cur]) begin
                rank[j] = rank[j-1];
                j--;
            end
            rank[j] = cur;
            gone[i] = 1'b0;
        end
        last_pos = -1;
        for (i = 0; i < set_count; i++) begin
            if (gone[i]) continue;
            for (j = i + 1; j < set_count; j++)
                if (!gone[j] && iou_above(set_geometry[rank[i]], set_geometry[rank[j]]))
                    gone[j] = 1'b1;
            r.source_index      = 6'(rank[i]);
            r.kept_x            = set_geometry[rank[i]][15:0];
            r.kept_y            = set_geometry[rank[i]][31:16];
            r.kept_width        = set_geometry[rank[i]][47:32];
            r.kept_height       = set_geometry[rank[i]][63:48];
            r.kept_score        = set_score[rank[i]];
            r.end_of_list       = 1'b0;
            r.capacity_exceeded = set_overflow;
            kept_queue = {kept_queue, r};
            last_pos = kept_queue.size() - 1;
        end
        if (last_pos >= 0) kept_queue[last_pos].end_of_list = 1'b1;
        set_count = 0;
        set_overflow = 1'b0;
    endtask

    // append one box to the pending queue
    task automatic enqueue_box(t_in b);
        box_queue = {box_queue, b};
    endtask

    // acceptance seen at the last rising edge
    logic o_in_ready_q;
    always @(posedge i_clk) o_in_ready_q <= i_in_valid && o_in_ready && i_rst_n;

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
        end else if (!i_in_valid || o_in_ready_q) begin
            if (box_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_data  <= box_queue.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: predict on accepted boxes, check each kept box
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) predict_box(i_in_data);
            if (o_out_valid && i_out_ready) begin
                if (kept_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected kept box %p", o_out_data);
                end else begin
                    t_out e;
                    e = kept_queue.pop_front();
                    if (e !== o_out_data) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("kept box differs: expected %p actual %p",
                                     e, o_out_data);
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stall_ticks <= 0;
            else
                stall_ticks <= stall_ticks + 1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (stall_ticks >= STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("box_non_maximum_suppression: mismatch");
            $finish;
        end
    end

    function automatic logic [15:0] pick_value();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // random box, clustered so that suppression happens often
    function automatic t_in random_box(logic [15:0] cx, logic [15:0] cy, bit last);
        t_in b;
        b.center_x   = ($urandom_range(9) == 0) ? pick_value() : cx + 16'($urandom_range(3000));
        b.center_y   = ($urandom_range(9) == 0) ? pick_value() : cy + 16'($urandom_range(3000));
        b.box_width  = ($urandom_range(9) == 0) ? pick_value() : 16'($urandom_range(16000));
        b.box_height = ($urandom_range(9) == 0) ? pick_value() : 16'($urandom_range(16000));
        b.confidence = ($urandom_range(4) == 0) ? 16'($urandom_range(3) * 16384)
                                                : 16'($urandom);
        b.final_box  = last;
        return b;
    endfunction

    function automatic t_in fixed_box(logic [15:0] x, logic [15:0] y, logic [15:0] w,
                                      logic [15:0] h, logic [15:0] s, bit last);
        t_in b;
        b.center_x = x; b.center_y = y; b.box_width = w; b.box_height = h;
        b.confidence = s; b.final_box = last;
        return b;
    endfunction

    task automatic apb_write(logic [15:0] value);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 2'(REG_THR * 4); pwdata <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        thr_model = value;
    endtask

    task automatic wait_drained();
        while (box_queue.size() > 0 || i_in_valid || kept_queue.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    task automatic random_sets(int boxes);
        int n, k, sent;
        logic [15:0] cx, cy;
        sent = 0;
        while (sent < boxes) begin
            case ($urandom_range(9))
                0: n = 1;
                1: n = CAPACITY + $urandom_range(1, 4);
                2: n = $urandom_range(30, CAPACITY);
                default: n = $urandom_range(2, 10);
            endcase
            cx = 16'($urandom);
            cy = 16'($urandom);
            for (k = 0; k < n; k++)
                enqueue_box(random_box(cx, cy, k == n - 1));
            sent += n;
        end
    endtask

    initial begin
        int k;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        thr_model = THR_RESET;
        send_idle_pct = 29; recv_idle_pct = 54;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: lone box, identical pair, tied scores, zero-area, field extremes
        enqueue_box(fixed_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1));
        enqueue_box(fixed_box(16'h8000, 16'h8000, 16'h1000, 16'h1000, 16'h1234, 0));
        enqueue_box(fixed_box(16'h8000, 16'h8000, 16'h1000, 16'h1000, 16'h1234, 1));
        enqueue_box(fixed_box(16'h4000, 16'h4000, 16'h0000, 16'h2000, 16'hFFFF, 0));
        enqueue_box(fixed_box(16'h4000, 16'h4000, 16'h2000, 16'h0000, 16'h0000, 0));
        enqueue_box(fixed_box(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0));
        enqueue_box(fixed_box(16'h4100, 16'h4000, 16'h2000, 16'h2000, 16'h7FFF, 1));
        wait_drained();

        // threshold zero: any overlap suppresses
        apb_write(16'h0000);
        enqueue_box(fixed_box(16'h1000, 16'h1000, 16'h0400, 16'h0400, 16'h0100, 0));
        enqueue_box(fixed_box(16'h1200, 16'h1000, 16'h0400, 16'h0400, 16'h0200, 0));
        enqueue_box(fixed_box(16'h2000, 16'h2000, 16'h0100, 16'h0100, 16'h0300, 1));
        wait_drained();

        // overflow set with final box dropped, at maximal threshold
        apb_write(16'hFFFF);
        for (k = 0; k < CAPACITY + 2; k++)
            enqueue_box(random_box(16'h2000, 16'h2000, k == CAPACITY + 1));
        wait_drained();

        // random phases across thresholds and idling patterns
        apb_write(THR_RESET);
        random_sets(110);
        wait_drained();
        send_idle_pct = 54; recv_idle_pct = 29;
        apb_write(16'($urandom));
        random_sets(110);
        wait_drained();
        send_idle_pct = 0; recv_idle_pct = 0;
        apb_write(16'h0000);
        random_sets(55);
        wait_drained();
        apb_write(16'hFFFF);
        random_sets(55);
        wait_drained();

        if (mismatches == 0 && kept_queue.size() == 0)
            $display("box_non_maximum_suppression: match");
        else
            $display("box_non_maximum_suppression: mismatch");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+design
design/bnms_pkg.sv
design/bnms_datapath.sv
design/bnms_ctrl.sv
design/box_non_maximum_suppression.sv
design/bnms_checker.sv
tb/box_non_maximum_suppression_tb.sv
